// ===== design/lzmf_pkg.sv =====
`timescale 1ns / 1ps

package lzmf_pkg;

   localparam int DATA_W      = 8;
   localparam int OUT_W       = 9;
   localparam int RSP_PAD_W   = 6;
   localparam int RSP_TDATA_W = 2 * OUT_W + RSP_PAD_W;

   // microprogram step addresses
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_INIT  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_CHKD  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_CHKN  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_CMP   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ADV   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_SCORE = 3'd6;
   localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
   localparam logic [COND_W-1:0] COND_NO_START = 3'd1;
   localparam logic [COND_W-1:0] COND_D_PAST   = 3'd2;
   localparam logic [COND_W-1:0] COND_N_DONE   = 3'd3;
   localparam logic [COND_W-1:0] COND_MISMATCH = 3'd4;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd5;

   typedef struct packed {
      logic idle;      // accepting loads
      logic clr_best;  // d = 1, best cleared
      logic clr_n;     // n = off = 0, base = window count - d
      logic adv;       // next byte pair
      logic score;     // keep longer match, next distance
      logic emit;      // load result, clear counts
   } action_type;

   typedef struct packed {
      action_type        act;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] jump_step;
      logic [STEP_W-1:0] next_step;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic d_past;
      logic n_done;
      logic mismatch;
      logic out_busy;
   } status_type;

   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      case (step)
         STEP_IDLE: begin
            w.act.idle  = 1'b1;
            w.cond      = COND_NO_START;
            w.jump_step = STEP_IDLE;
            w.next_step = STEP_INIT;
         end
         STEP_INIT: begin
            w.act.clr_best = 1'b1;
            w.cond         = COND_ALWAYS;
            w.jump_step    = STEP_CHKD;
            w.next_step    = STEP_CHKD;
         end
         STEP_CHKD: begin
            w.act.clr_n = 1'b1;
            w.cond      = COND_D_PAST;
            w.jump_step = STEP_DONE;
            w.next_step = STEP_CHKN;
         end
         STEP_CHKN: begin
            w.cond      = COND_N_DONE;
            w.jump_step = STEP_SCORE;
            w.next_step = STEP_CMP;
         end
         STEP_CMP: begin
            w.cond      = COND_MISMATCH;
            w.jump_step = STEP_SCORE;
            w.next_step = STEP_ADV;
         end
         STEP_ADV: begin
            w.act.adv   = 1'b1;
            w.cond      = COND_ALWAYS;
            w.jump_step = STEP_CHKN;
            w.next_step = STEP_CHKN;
         end
         STEP_SCORE: begin
            w.act.score = 1'b1;
            w.cond      = COND_ALWAYS;
            w.jump_step = STEP_CHKD;
            w.next_step = STEP_CHKD;
         end
         STEP_DONE: begin
            w.act.emit  = 1'b1;
            w.cond      = COND_OUT_BUSY;
            w.jump_step = STEP_DONE;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.cond      = COND_ALWAYS;
            w.jump_step = STEP_IDLE;
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/lzmf_seq.sv =====
`timescale 1ns / 1ps

module lzmf_seq import lzmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output action_type act
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctrl_word_type     word;
   logic              taken;

   assign word = rom_word(step_ff);
   assign act  = word.act;

   always_comb begin
      case (word.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_START: taken = !status.start;
         COND_D_PAST:   taken = status.d_past;
         COND_N_DONE:   taken = status.n_done;
         COND_MISMATCH: taken = status.mismatch;
         COND_OUT_BUSY: taken = status.out_busy;
         default:       taken = 1'b1;
      endcase
      step_in = taken ? word.jump_step : word.next_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== design/lz_longest_match_finder.sv =====
`timescale 1ns / 1ps

// Longest-match search for an LZ77 style coder. Each req transfer appends one byte to the
// search window (tuser = 0) or to the lookahead buffer (tuser = 1); bytes beyond a
// buffer's size are dropped. The transfer with tlast stores its byte and starts the
// search: every backward distance d from 1 to the window count is tried, nearest first,
// overlapping copies included, and the first distance with the longest match is sent on
// rsp as distance and length (0 and 0 when nothing matches). Both buffers are then empty.
// The search is run by a small microprogram over one registered read port per buffer:
// for each distance it sets up the candidate, compares byte pairs one at a time until a
// mismatch or the end of the lookahead, then keeps the match if it is longer. req_tready
// stays low during the search and until the result has a free output register.
module lz_longest_match_finder import lzmf_pkg::*; #(
   parameter int WINDOW_SIZE    = 256,
   parameter int LOOKAHEAD_SIZE = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // data_byte
   input  logic                   req_tuser,   // cmd
   input  logic                   req_tlast,   // last
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // distance[8:0], length[17:9], zero pad
);

   localparam int WAW = $clog2(WINDOW_SIZE);
   localparam int LAW = $clog2(LOOKAHEAD_SIZE);
   localparam int WCW = $clog2(WINDOW_SIZE + 1);
   localparam int LCW = $clog2(LOOKAHEAD_SIZE + 1);
   localparam int DW  = $clog2(WINDOW_SIZE + 2);

   logic [DATA_W-1:0] win_mem [WINDOW_SIZE];
   logic [DATA_W-1:0] la_mem  [LOOKAHEAD_SIZE];

   logic [WCW-1:0]         wcount_ff, wcount_in;
   logic [LCW-1:0]         lcount_ff, lcount_in;
   logic [DW-1:0]          d_ff, d_in;
   logic [WCW-1:0]         off_ff, off_in;
   logic [WCW-1:0]         base_ff, base_in;
   logic [LCW-1:0]         n_ff, n_in;
   logic [WCW-1:0]         best_d_ff, best_d_in;
   logic [LCW-1:0]         best_len_ff, best_len_in;
   logic [DATA_W-1:0]      win_q_ff, la_q_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   action_type     act;
   status_type     status;
   logic           req_accept;
   logic           win_we, la_we;
   logic [WCW-1:0] win_addr_full;
   logic [WCW-1:0] off_inc;
   logic           emit_fire;

   lzmf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .act    (act)
   );

   assign req_tready = act.idle;
   assign req_accept = req_tvalid && act.idle;
   assign win_we     = req_accept && !req_tuser && (wcount_ff < WCW'(WINDOW_SIZE));
   assign la_we      = req_accept && req_tuser && (lcount_ff < LCW'(LOOKAHEAD_SIZE));

   assign win_addr_full = base_ff + off_ff;
   assign off_inc       = off_ff + 1'b1;

   assign status.start    = req_accept && req_tlast;
   assign status.d_past   = d_ff > DW'(wcount_ff);
   assign status.n_done   = n_ff >= lcount_ff;
   assign status.mismatch = la_q_ff != win_q_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   assign emit_fire = act.emit && !status.out_busy;

   // window and lookahead stores, one registered read port each
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[wcount_ff[WAW-1:0]] <= req_tdata;
      end
      win_q_ff <= win_mem[win_addr_full[WAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (la_we) begin
         la_mem[lcount_ff[LAW-1:0]] <= req_tdata;
      end
      la_q_ff <= la_mem[n_ff[LAW-1:0]];
   end

   always_comb begin
      wcount_in    = wcount_ff;
      lcount_in    = lcount_ff;
      d_in         = d_ff;
      off_in       = off_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      best_d_in    = best_d_ff;
      best_len_in  = best_len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (win_we) begin
         wcount_in = wcount_ff + 1'b1;
      end
      if (la_we) begin
         lcount_in = lcount_ff + 1'b1;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (act.clr_best) begin
         d_in        = DW'(1);
         best_d_in   = '0;
         best_len_in = '0;
      end
      if (act.clr_n) begin
         n_in    = '0;
         off_in  = '0;
         base_in = wcount_ff - d_ff[WCW-1:0];
      end
      if (act.adv) begin
         n_in   = n_ff + 1'b1;
         // overlapping copy: wrap back to the start of the candidate
         off_in = (DW'(off_inc) == d_ff) ? '0 : off_inc;
      end
      if (act.score) begin
         if (n_ff > best_len_ff) begin
            best_len_in = n_ff;
            best_d_in   = d_ff[WCW-1:0];
         end
         d_in = d_ff + 1'b1;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, OUT_W'(best_len_ff), OUT_W'(best_d_ff)};
         wcount_in    = '0;
         lcount_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff    <= '0;
         lcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wcount_ff    <= wcount_in;
         lcount_ff    <= lcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      off_ff      <= off_in;
      base_ff     <= base_in;
      n_ff        <= n_in;
      best_d_ff   <= best_d_in;
      best_len_ff <= best_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/lzmf_checker.sv =====
`timescale 1ns / 1ps

module lzmf_checker import lzmf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a transfer with tlast starts the search, so no further loads next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("loads accepted right after a search start");

   // a new result is only produced by the search, while loads are held off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while loads were accepted");

   // after the result is loaded the block goes straight back to taking bytes
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("block not ready for loads after giving a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind lz_longest_match_finder lzmf_checker u_lzmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
